// ----- rtl/rthsv_pkg.sv -----
package rthsv_pkg;

  // input and result field widths
  localparam int CHAN_W = 8;
  localparam int HUE_W  = 15;
  localparam int SAT_W  = 13;

  // divider widths: remainders hold numerators below 2^20, quotients reach 4096
  localparam int REM_W = 21;
  localparam int QUO_W = 13;

  // number of divide cells, one per quotient bit
  localparam int NUM_CELLS = QUO_W;

  // hue sector bases in 1/64 degree
  localparam logic [HUE_W-1:0] HUE_BASE_RED   = 15'd0;
  localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_BASE_WRAP  = 15'd23040;

  // work carried down the divider chain
  typedef struct packed {
    logic [REM_W-1:0]  hue_rem;
    logic [QUO_W-1:0]  hue_quo;
    logic [CHAN_W-1:0] delta;
    logic [REM_W-1:0]  sat_rem;
    logic [QUO_W-1:0]  sat_quo;
    logic [CHAN_W-1:0] maxv;
    logic [HUE_W-1:0]  hue_base;
    logic              hue_neg;
    logic              grey;
    logic              black;
  } cell_t;

endpackage

// ----- rtl/rgb_to_hsv_converter.sv -----
// rgb to hsv pixel converter
// pipeline: an accepted input beat passes through
//   one sort stage, 13 divide cells and one output stage to its output beat
// throughput: one pixel per clock unless m_tready stalls; every stage holds its own beat
// reset: synchronous active-high rst empties every stage; payload registers are not reset
module rgb_to_hsv_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // hue_out [14:0], sat_out [27:15], val_out [35:28], zero [39:36]
);

  localparam int N = rthsv_pkg::NUM_CELLS;

  logic             stg_valid [N+1];
  logic             stg_ready [N+1];
  rthsv_pkg::cell_t stg_data  [N+1];

  logic [rthsv_pkg::HUE_W-1:0]  hue_out;
  logic [rthsv_pkg::SAT_W-1:0]  sat_out;
  logic [rthsv_pkg::CHAN_W-1:0] val_out;

  // min, max and numerators
  rthsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .red_in    (s_tdata[7:0]),
    .green_in  (s_tdata[15:8]),
    .blue_in   (s_tdata[23:16]),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_data  (stg_data[0])
  );

  // row of divide cells, most significant quotient bit first
  for (genvar i = 0; i < N; i++) begin : g_cell
    rthsv_cell #(
      .SHIFT (N - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_data   (stg_data[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_data  (stg_data[i+1])
    );
  end

  // sign fixup and output register
  rthsv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid[N]),
    .in_ready  (stg_ready[N]),
    .in_data   (stg_data[N]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .hue_out   (hue_out),
    .sat_out   (sat_out),
    .val_out   (val_out)
  );

  assign m_tdata = {4'b0000, val_out, sat_out, hue_out};

endmodule

// ----- rtl/rthsv_front.sv -----
module rthsv_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rthsv_pkg::CHAN_W-1:0]    red_in,
  input  logic [rthsv_pkg::CHAN_W-1:0]    green_in,
  input  logic [rthsv_pkg::CHAN_W-1:0]    blue_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rthsv_pkg::cell_t                out_data
);

  logic [rthsv_pkg::CHAN_W-1:0] maxv;
  logic [rthsv_pkg::CHAN_W-1:0] minv;
  logic [rthsv_pkg::CHAN_W-1:0] delta;
  logic [rthsv_pkg::CHAN_W-1:0] pos;
  logic [rthsv_pkg::CHAN_W-1:0] neg;
  logic [rthsv_pkg::CHAN_W-1:0] mag;
  logic [rthsv_pkg::HUE_W-1:0]  base;
  logic                         flip;
  rthsv_pkg::cell_t             data_next;

  // largest and smallest channel
  always_comb begin
    maxv = (red_in > green_in) ? red_in : green_in;
    maxv = (maxv > blue_in) ? maxv : blue_in;
    minv = (red_in < green_in) ? red_in : green_in;
    minv = (minv < blue_in) ? minv : blue_in;
    delta = maxv - minv;
  end

  // hue sector: base, operands of the difference and whether it is subtracted
  always_comb begin
    if (maxv == red_in) begin
      pos = green_in;
      neg = blue_in;
      if (green_in >= blue_in) begin
        base = rthsv_pkg::HUE_BASE_RED;
        flip = 1'b0;
      end else begin
        base = rthsv_pkg::HUE_BASE_WRAP;
        flip = 1'b1;
      end
    end else if (maxv == green_in) begin
      pos  = blue_in;
      neg  = red_in;
      base = rthsv_pkg::HUE_BASE_GREEN;
      flip = (blue_in < red_in);
    end else begin
      pos  = red_in;
      neg  = green_in;
      base = rthsv_pkg::HUE_BASE_BLUE;
      flip = (red_in < green_in);
    end
    mag = (pos >= neg) ? (pos - neg) : (neg - pos);
  end

  // numerators: 3840*mag as 4096*mag - 256*mag, and 4096*delta
  always_comb begin
    data_next.hue_rem  = (rthsv_pkg::REM_W'(mag) << 12) - (rthsv_pkg::REM_W'(mag) << 8);
    data_next.hue_quo  = '0;
    data_next.delta    = delta;
    data_next.sat_rem  = rthsv_pkg::REM_W'(delta) << 12;
    data_next.sat_quo  = '0;
    data_next.maxv     = maxv;
    data_next.hue_base = base;
    data_next.hue_neg  = flip;
    data_next.grey     = (delta == '0);
    data_next.black    = (maxv == '0);
  end

  assign in_ready = !out_valid || out_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/rthsv_cell.sv -----
module rthsv_cell #(
  parameter int SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rthsv_pkg::cell_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rthsv_pkg::cell_t out_data
);

  logic [rthsv_pkg::REM_W-1:0] hue_dsh;
  logic [rthsv_pkg::REM_W-1:0] sat_dsh;
  logic [rthsv_pkg::QUO_W-1:0] qbit;
  rthsv_pkg::cell_t            data_next;

  // divisors aligned to this cell's quotient bit
  assign hue_dsh = rthsv_pkg::REM_W'(in_data.delta) << SHIFT;
  assign sat_dsh = rthsv_pkg::REM_W'(in_data.maxv) << SHIFT;
  assign qbit    = rthsv_pkg::QUO_W'(1) << SHIFT;

  // one restoring step on each lane
  always_comb begin
    data_next = in_data;
    if (in_data.hue_rem >= hue_dsh) begin
      data_next.hue_rem = in_data.hue_rem - hue_dsh;
      data_next.hue_quo = in_data.hue_quo | qbit;
    end
    if (in_data.sat_rem >= sat_dsh) begin
      data_next.sat_rem = in_data.sat_rem - sat_dsh;
      data_next.sat_quo = in_data.sat_quo | qbit;
    end
  end

  assign in_ready = !out_valid || out_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/rthsv_back.sv -----
module rthsv_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rthsv_pkg::cell_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rthsv_pkg::HUE_W-1:0]  hue_out,
  output logic [rthsv_pkg::SAT_W-1:0]  sat_out,
  output logic [rthsv_pkg::CHAN_W-1:0] val_out
);

  logic [rthsv_pkg::HUE_W-1:0] quo_ext;
  logic [rthsv_pkg::HUE_W-1:0] hue_next;
  logic [rthsv_pkg::SAT_W-1:0] sat_next;

  // apply sector base and sign, zero the hue of grey pixels and the saturation of black pixels
  always_comb begin
    quo_ext = rthsv_pkg::HUE_W'(in_data.hue_quo);
    if (in_data.grey) begin
      hue_next = '0;
    end else if (in_data.hue_neg) begin
      hue_next = in_data.hue_base - quo_ext;
    end else begin
      hue_next = in_data.hue_base + quo_ext;
    end
    sat_next = in_data.black ? '0 : rthsv_pkg::SAT_W'(in_data.sat_quo);
  end

  assign in_ready = !out_valid || out_ready;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hue_out <= hue_next;
      sat_out <= sat_next;
      val_out <= in_data.maxv;
    end
  end

endmodule
